// ===== hdl/prc_pkg.sv =====
// Shared constants, angle type and arctangent table for the point range and
// heading sector crop. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUAT_W          = 16;
    localparam int RADIUS_W        = 31;
    localparam int CFG_IDX_W       = 4;

    // heading terms are Q5.28, at most 34 bits signed
    localparam int HEAD_IN_W       = 34;

    localparam int ANG_W           = 17;
    localparam int CORDIC_ITERS    = 14;
    localparam int NORM_MSB        = 40;
    localparam int ANG_PI          = 25736;
    localparam int ANG_TWO_PI      = 51472;
    localparam int ANG_SECTOR      = 6554;

    localparam logic [CFG_IDX_W-1:0] REG_POS_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Z       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_W      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_X      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_RADIUS = 4'd7;

    localparam logic signed [QUAT_W-1:0] QUAT_W_RST   = 16'sd16384;
    localparam logic [RADIUS_W-1:0]      RADIUS_RST   = 31'd13107;

    typedef logic signed [ANG_W-1:0] ang_t;

    // rounded Q3.13 arctangent of 2^-idx
    function automatic ang_t atan_q13(input int idx);
        ang_t a;
        case (idx)
            0:       a = 17'sd6434;
            1:       a = 17'sd3798;
            2:       a = 17'sd2007;
            3:       a = 17'sd1019;
            4:       a = 17'sd511;
            5:       a = 17'sd256;
            6:       a = 17'sd128;
            7:       a = 17'sd64;
            8:       a = 17'sd32;
            9:       a = 17'sd16;
            10:      a = 17'sd8;
            11:      a = 17'sd4;
            12:      a = 17'sd2;
            13:      a = 17'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/prc_cordic.sv =====
// Pipelined CORDIC vectoring unit: atan2(y, x) in Q3.13, one stage per step.
// Depends on prc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prc_cordic #(
    parameter int IN_W = 33
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        ce,
    input  wire                        in_valid,
    input  wire signed [IN_W-1:0]      in_x,
    input  wire signed [IN_W-1:0]      in_y,
    output logic                       out_valid,
    output prc_pkg::ang_t              out_ang
);

    localparam int AW    = IN_W + 1;
    localparam int DW    = ((IN_W + 3) > (prc_pkg::NORM_MSB + 4)) ?
                           (IN_W + 3) : (prc_pkg::NORM_MSB + 4);
    localparam int MSB_W = $clog2(AW);
    localparam int SH_W  = $clog2(prc_pkg::NORM_MSB + 1);
    localparam int ITERS = prc_pkg::CORDIC_ITERS;

    // stage A: fold left half plane
    logic signed [AW-1:0] a_x_reg, a_y_reg;
    logic [AW-1:0]        a_mag_reg;
    prc_pkg::ang_t        a_ang_reg;
    logic                 a_zero_reg, a_valid_reg;

    logic signed [AW-1:0] a_x_next, a_y_next, a_y_abs;
    prc_pkg::ang_t        a_ang_next;

    always_comb begin
        a_x_next   = AW'(in_x);
        a_y_next   = AW'(in_y);
        a_ang_next = '0;
        if (in_x < 0) begin
            a_x_next   = -AW'(in_x);
            a_y_next   = -AW'(in_y);
            a_ang_next = (in_y >= 0) ? prc_pkg::ANG_W'(prc_pkg::ANG_PI)
                                     : -prc_pkg::ANG_W'(prc_pkg::ANG_PI);
        end
        a_y_abs = (a_y_next < 0) ? -a_y_next : a_y_next;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_x_reg    <= a_x_next;
            a_y_reg    <= a_y_next;
            a_ang_reg  <= a_ang_next;
            a_mag_reg  <= a_x_next | a_y_abs;
            a_zero_reg <= (in_x == 0) && (in_y == 0);
        end
    end

    // stage B: find the leading one, derive the normalising shift
    logic signed [AW-1:0] b_x_reg, b_y_reg;
    prc_pkg::ang_t        b_ang_reg;
    logic [SH_W-1:0]      b_sh_reg;
    logic                 b_zero_reg, b_valid_reg;
    logic [MSB_W-1:0]     b_msb;
    logic [SH_W-1:0]      b_sh_next;

    always_comb begin
        b_msb = '0;
        for (int b = 0; b < AW; b++) begin
            if (a_mag_reg[b]) begin
                b_msb = MSB_W'(b);
            end
        end
        b_sh_next = (int'(b_msb) >= prc_pkg::NORM_MSB) ? '0
                  : SH_W'(prc_pkg::NORM_MSB - int'(b_msb));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            b_ang_reg  <= a_ang_reg;
            b_sh_reg   <= b_sh_next;
            b_zero_reg <= a_zero_reg;
        end
    end

    // stage C onward: normalise, then one micro-rotation per stage
    logic signed [DW-1:0] it_x_reg   [0:ITERS];
    logic signed [DW-1:0] it_y_reg   [0:ITERS];
    prc_pkg::ang_t        it_ang_reg [0:ITERS];
    logic                 it_zero_reg [0:ITERS];
    logic [ITERS:0]       it_valid_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            it_x_reg[0]    <= DW'(b_x_reg) <<< b_sh_reg;
            it_y_reg[0]    <= DW'(b_y_reg) <<< b_sh_reg;
            it_ang_reg[0]  <= b_ang_reg;
            it_zero_reg[0] <= b_zero_reg;
            for (int i = 0; i < ITERS; i++) begin
                it_zero_reg[i+1] <= it_zero_reg[i];
                if (!it_y_reg[i][DW-1]) begin
                    it_x_reg[i+1]   <= it_x_reg[i] + (it_y_reg[i] >>> i);
                    it_y_reg[i+1]   <= it_y_reg[i] - (it_x_reg[i] >>> i);
                    it_ang_reg[i+1] <= it_ang_reg[i] + prc_pkg::atan_q13(i);
                end else begin
                    it_x_reg[i+1]   <= it_x_reg[i] - (it_y_reg[i] >>> i);
                    it_y_reg[i+1]   <= it_y_reg[i] + (it_x_reg[i] >>> i);
                    it_ang_reg[i+1] <= it_ang_reg[i] - prc_pkg::atan_q13(i);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            it_valid_reg <= '0;
        end else if (ce) begin
            a_valid_reg  <= in_valid;
            b_valid_reg  <= a_valid_reg;
            it_valid_reg <= {it_valid_reg[ITERS-1:0], b_valid_reg};
        end
    end

    assign out_valid = it_valid_reg[ITERS];
    assign out_ang   = it_zero_reg[ITERS] ? '0 : it_ang_reg[ITERS];

endmodule

`default_nettype wire

// ===== hdl/prc_near.sv =====
// Near-radius test over three stages: bound check, squares, sum and compare.
// Depends on prc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prc_near #(
    parameter int DW = 33
) (
    input  wire                              aclk,
    input  wire                              ce,
    input  wire signed [DW-1:0]              dx,
    input  wire signed [DW-1:0]              dy,
    input  wire signed [DW-1:0]              dz,
    input  wire [prc_pkg::RADIUS_W-1:0]      radius,
    output logic                             near
);

    localparam int RW = prc_pkg::RADIUS_W;
    localparam int CW = (DW > RW) ? DW : RW;

    logic [CW-1:0] ax, ay, az, rad_ext;

    always_comb begin
        ax      = CW'(unsigned'((dx < 0) ? -dx : dx));
        ay      = CW'(unsigned'((dy < 0) ? -dy : dy));
        az      = CW'(unsigned'((dz < 0) ? -dz : dz));
        rad_ext = CW'(radius);
    end

    logic [RW-1:0]   s1_ax_reg, s1_ay_reg, s1_az_reg;
    logic            s1_in_reg;
    logic [2*RW-1:0] s2_sx_reg, s2_sy_reg, s2_sz_reg, s2_rr_reg;
    logic            s2_in_reg;
    logic            s3_near_reg;
    logic [2*RW+1:0] sum;

    // components beyond the radius mean far; hold only the low bits otherwise
    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_ax_reg <= ax[RW-1:0];
            s1_ay_reg <= ay[RW-1:0];
            s1_az_reg <= az[RW-1:0];
            s1_in_reg <= (ax <= rad_ext) && (ay <= rad_ext) && (az <= rad_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_sx_reg <= s1_ax_reg * s1_ax_reg;
            s2_sy_reg <= s1_ay_reg * s1_ay_reg;
            s2_sz_reg <= s1_az_reg * s1_az_reg;
            s2_rr_reg <= radius * radius;
            s2_in_reg <= s1_in_reg;
        end
    end

    assign sum = (2*RW+2)'(s2_sx_reg) + (2*RW+2)'(s2_sy_reg) + (2*RW+2)'(s2_sz_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_near_reg <= s2_in_reg && (sum <= (2*RW+2)'(s2_rr_reg));
        end
    end

    assign near = s3_near_reg;

endmodule

`default_nettype wire

// ===== hdl/point_range_and_heading_sector_crop_top.sv =====
// Top level of the point range and heading sector crop.
// Depends on prc_pkg, prc_cordic and prc_near.
//
// Usage
//   s_ channel: one lidar point (x, y, z, Q16.16) per item, valid/ready.
//   m_ channel: the same point, unchanged, when it is kept; nothing otherwise.
//   cfg port: write enable, register index and data; write only while idle.
//   A point is dropped when it lies within near_radius of the vehicle, or
//   when its planar bearing is more than 0.8 rad from the pose heading.
// Timing
//   One item per cycle while the output buffer is not full. On the way to
//   m_valid the entry stage registers the item at the accepting edge, then
//   17 stages of the CORDIC unit (fold, leading-one search, normalising
//   shift, 14 micro-rotations), one angle-difference stage and the output
//   buffer. The heading runs in a second CORDIC lane beside the bearing.
// Reset and stalls
//   Reset empties the pipeline and output buffer and loads the register
//   defaults: vehicle at origin, identity quaternion, radius 0.2 m.
//   A two-entry output buffer takes the pipeline's results; the whole
//   pipeline holds only when that buffer is full, so s_ready is a register
//   decode and new items keep flowing while one result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module point_range_and_heading_sector_crop_top #(
    parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF,
    localparam int CFG_W = (COORD_WIDTH > prc_pkg::RADIUS_W) ?
                           COORD_WIDTH : prc_pkg::RADIUS_W
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire signed [COORD_WIDTH-1:0]     s_point_x,
    input  wire signed [COORD_WIDTH-1:0]     s_point_y,
    input  wire signed [COORD_WIDTH-1:0]     s_point_z,

    output logic                             m_valid,
    input  wire                              m_ready,
    output logic signed [COORD_WIDTH-1:0]    m_out_x,
    output logic signed [COORD_WIDTH-1:0]    m_out_y,
    output logic signed [COORD_WIDTH-1:0]    m_out_z,

    input  wire                              cfg_wr_en,
    input  wire [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [CFG_W-1:0]                  cfg_wdata
);

    localparam int DW       = COORD_WIDTH + 1;
    localparam int QW       = prc_pkg::QUAT_W;
    localparam int HW       = prc_pkg::HEAD_IN_W;
    localparam int LAT_C    = 3 + prc_pkg::CORDIC_ITERS;
    localparam int LAT_N    = 3;
    localparam int NEAR_DLY = LAT_C - LAT_N;
    localparam int DIFF_W   = prc_pkg::ANG_W + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0]   pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [QW-1:0]            quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic [prc_pkg::RADIUS_W-1:0]    near_radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            pos_z_reg       <= '0;
            quat_w_reg      <= prc_pkg::QUAT_W_RST;
            quat_x_reg      <= '0;
            quat_y_reg      <= '0;
            quat_z_reg      <= '0;
            near_radius_reg <= prc_pkg::RADIUS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                prc_pkg::REG_POS_X:       pos_x_reg  <= cfg_wdata[COORD_WIDTH-1:0];
                prc_pkg::REG_POS_Y:       pos_y_reg  <= cfg_wdata[COORD_WIDTH-1:0];
                prc_pkg::REG_POS_Z:       pos_z_reg  <= cfg_wdata[COORD_WIDTH-1:0];
                prc_pkg::REG_QUAT_W:      quat_w_reg <= cfg_wdata[QW-1:0];
                prc_pkg::REG_QUAT_X:      quat_x_reg <= cfg_wdata[QW-1:0];
                prc_pkg::REG_QUAT_Y:      quat_y_reg <= cfg_wdata[QW-1:0];
                prc_pkg::REG_QUAT_Z:      quat_z_reg <= cfg_wdata[QW-1:0];
                prc_pkg::REG_NEAR_RADIUS:
                    near_radius_reg <= cfg_wdata[prc_pkg::RADIUS_W-1:0];
                default: ;  // unknown index: ignore the write
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline advance: hold everything only while the output buffer is full
    // ---------------------------------------------------------------
    logic [1:0] cnt_reg;
    logic       ce;

    assign ce      = (cnt_reg != 2'd2);
    assign s_ready = ce;

    // ---------------------------------------------------------------
    // Entry stage: offsets from the vehicle and quaternion products
    // ---------------------------------------------------------------
    logic                          s0_valid_reg;
    logic signed [DW-1:0]          s0_dx_reg, s0_dy_reg, s0_dz_reg;
    logic signed [COORD_WIDTH-1:0] s0_px_reg, s0_py_reg, s0_pz_reg;
    logic signed [2*QW-1:0]        s0_wz_reg, s0_xy_reg, s0_yy_reg, s0_zz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (ce) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s0_dx_reg <= DW'(s_point_x) - DW'(pos_x_reg);
            s0_dy_reg <= DW'(s_point_y) - DW'(pos_y_reg);
            s0_dz_reg <= DW'(s_point_z) - DW'(pos_z_reg);
            s0_px_reg <= s_point_x;
            s0_py_reg <= s_point_y;
            s0_pz_reg <= s_point_z;
            s0_wz_reg <= quat_w_reg * quat_z_reg;
            s0_xy_reg <= quat_x_reg * quat_y_reg;
            s0_yy_reg <= quat_y_reg * quat_y_reg;
            s0_zz_reg <= quat_z_reg * quat_z_reg;
        end
    end

    // heading terms in Q5.28
    logic signed [HW-1:0] head_num, head_den;

    assign head_num = (HW'(s0_wz_reg) + HW'(s0_xy_reg)) <<< 1;
    assign head_den = (HW'(1) <<< 28) - ((HW'(s0_yy_reg) + HW'(s0_zz_reg)) <<< 1);

    // ---------------------------------------------------------------
    // Bearing and heading lanes, near test beside them
    // ---------------------------------------------------------------
    logic          brg_valid, yaw_valid;
    prc_pkg::ang_t brg_ang, yaw_ang;
    logic          near_flag;

    prc_cordic #(.IN_W(DW)) u_brg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s0_valid_reg),
        .in_x      (s0_dx_reg),
        .in_y      (s0_dy_reg),
        .out_valid (brg_valid),
        .out_ang   (brg_ang)
    );

    prc_cordic #(.IN_W(HW)) u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s0_valid_reg),
        .in_x      (head_den),
        .in_y      (head_num),
        .out_valid (yaw_valid),
        .out_ang   (yaw_ang)
    );

    prc_near #(.DW(DW)) u_near (
        .aclk   (aclk),
        .ce     (ce),
        .dx     (s0_dx_reg),
        .dy     (s0_dy_reg),
        .dz     (s0_dz_reg),
        .radius (near_radius_reg),
        .near   (near_flag)
    );

    // delay the point and the near flag to meet the angles
    logic signed [COORD_WIDTH-1:0] pd_x_reg [0:LAT_C-1];
    logic signed [COORD_WIDTH-1:0] pd_y_reg [0:LAT_C-1];
    logic signed [COORD_WIDTH-1:0] pd_z_reg [0:LAT_C-1];
    logic                          nd_reg   [0:NEAR_DLY-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            pd_x_reg[0] <= s0_px_reg;
            pd_y_reg[0] <= s0_py_reg;
            pd_z_reg[0] <= s0_pz_reg;
            for (int i = 1; i < LAT_C; i++) begin
                pd_x_reg[i] <= pd_x_reg[i-1];
                pd_y_reg[i] <= pd_y_reg[i-1];
                pd_z_reg[i] <= pd_z_reg[i-1];
            end
            nd_reg[0] <= near_flag;
            for (int i = 1; i < NEAR_DLY; i++) begin
                nd_reg[i] <= nd_reg[i-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Angle difference stage
    // ---------------------------------------------------------------
    logic                          d_valid_reg, d_near_reg;
    logic [DIFF_W-1:0]             d_diff_reg;
    logic signed [COORD_WIDTH-1:0] d_x_reg, d_y_reg, d_z_reg;
    logic signed [DIFF_W-1:0]      diff_raw;

    assign diff_raw = DIFF_W'(brg_ang) - DIFF_W'(yaw_ang);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (ce) begin
            d_valid_reg <= brg_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_diff_reg <= unsigned'((diff_raw < 0) ? -diff_raw : diff_raw);
            d_near_reg <= nd_reg[NEAR_DLY-1];
            d_x_reg    <= pd_x_reg[LAT_C-1];
            d_y_reg    <= pd_y_reg[LAT_C-1];
            d_z_reg    <= pd_z_reg[LAT_C-1];
        end
    end

    // wrap around two pi, then test against the sector half-width
    logic signed [DIFF_W:0] diff_s, alt, wrapped, wrapped_abs;
    logic                   keep, push, pop;

    always_comb begin
        diff_s      = signed'((DIFF_W+1)'(d_diff_reg));
        alt         = (DIFF_W+1)'(prc_pkg::ANG_TWO_PI) - diff_s;
        wrapped     = (alt < diff_s) ? alt : diff_s;
        wrapped_abs = (wrapped < 0) ? -wrapped : wrapped;
        keep        = !d_near_reg && (wrapped_abs <= (DIFF_W+1)'(prc_pkg::ANG_SECTOR));
    end

    assign push = ce && d_valid_reg && keep;
    assign pop  = m_valid && m_ready;

    // ---------------------------------------------------------------
    // Two-entry output buffer
    // ---------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] ob_x_reg [0:1];
    logic signed [COORD_WIDTH-1:0] ob_y_reg [0:1];
    logic signed [COORD_WIDTH-1:0] ob_z_reg [0:1];
    logic                          wr_ptr_reg, rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            ob_x_reg[wr_ptr_reg] <= d_x_reg;
            ob_y_reg[wr_ptr_reg] <= d_y_reg;
            ob_z_reg[wr_ptr_reg] <= d_z_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_out_x = ob_x_reg[rd_ptr_reg];
    assign m_out_y = ob_y_reg[rd_ptr_reg];
    assign m_out_z = ob_z_reg[rd_ptr_reg];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        brg_valid == yaw_valid)
        else $error("bearing and heading lanes out of step");

    a_near_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (d_valid_reg && d_near_reg) |-> !push)
        else $error("near point pushed to output");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("output buffer count lost an item");

endmodule

`default_nettype wire
